// ===== design/perm_enum_pkg.sv =====
// shared constants and types of the permutation enumerator
// no dependencies; used by perm_enum_find, permutation_enumerator_core and the testbench
`timescale 1ns / 1ps
`default_nettype none

package perm_enum_pkg;

   localparam int MAX_ELEMENTS_DEF = 8;
   localparam int VAL_W            = 4;
   localparam int DIGITS_W         = 32;
   localparam int COUNT_W          = 16;
   localparam int SHOWN_MAX        = DIGITS_W / VAL_W;

   typedef struct packed {
      logic             found;
      logic [VAL_W-1:0] value;
   } find_result_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_BACK = 4'b0010,
      ST_FILL = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

endpackage

`default_nettype wire

// ===== design/perm_enum_find.sv =====
// shared search unit: smallest unused value above a floor and up to a limit
// depends on perm_enum_pkg
`timescale 1ns / 1ps
`default_nettype none

module perm_enum_find #(
   parameter int MAX_ELEMENTS = perm_enum_pkg::MAX_ELEMENTS_DEF
) (
   input  logic [MAX_ELEMENTS-1:0]              used_mask,
   input  logic [perm_enum_pkg::VAL_W-1:0]      floor_value,
   input  logic [perm_enum_pkg::VAL_W-1:0]      limit_value,
   output perm_enum_pkg::find_result_type       result
);

   always_comb begin
      result = '0;
      for (int w = MAX_ELEMENTS; w >= 1; w--) begin
         if (w > int'(floor_value) && w <= int'(limit_value) && !used_mask[w-1]) begin
            result.found = 1'b1;
            result.value = perm_enum_pkg::VAL_W'(w);
         end
      end
   end

endmodule

`default_nettype wire

// ===== design/permutation_enumerator_core.sv =====
// top level of the permutation enumerator: sequencer, state and output word
// depends on perm_enum_pkg and perm_enum_find
//
// Usage: each request word on req_ (valid/stall) carries req_restart. A restart,
// or any request before the first start or after csr_write_data was written,
// yields the first permutation 1..n; otherwise the next permutation in
// lexicographic order. One response word on rsp_ per request: packed digits,
// running count, exhausted flag (digits zero once all n! were given).
// A restart or a request after exhaustion goes straight to the emit step and the
// response register. A next request backtracks one level per cycle and then
// refills one position per cycle through the shared search unit, then emits.
// req_stall is high while a word is being worked on; the response register
// lets a new request be taken while the previous response is still stalled.
// A finished response waits in the sequencer while rsp_stall holds the
// previous one. Reset (synchronous) clears the search state and sets n to 4.
// csr_write_data is written only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module permutation_enumerator_core #(
   parameter int MAX_ELEMENTS = perm_enum_pkg::MAX_ELEMENTS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [perm_enum_pkg::VAL_W-1:0]      csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_restart,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [perm_enum_pkg::DIGITS_W-1:0]   rsp_perm_digits,
   output logic [perm_enum_pkg::COUNT_W-1:0]    rsp_perm_number,
   output logic                                 rsp_exhausted
);

   localparam int VAL_W   = perm_enum_pkg::VAL_W;
   localparam int IDX_W   = $clog2(MAX_ELEMENTS);
   localparam int SHOWN   = (MAX_ELEMENTS < perm_enum_pkg::SHOWN_MAX) ?
                            MAX_ELEMENTS : perm_enum_pkg::SHOWN_MAX;
   localparam logic [VAL_W-1:0] MAX_CNT = VAL_W'(MAX_ELEMENTS);
   localparam logic [MAX_ELEMENTS-1:0] ONE_BIT = MAX_ELEMENTS'(1);

   perm_enum_pkg::state_type state_ff, state_in;
   logic [VAL_W-1:0]  count_ff, count_in;
   logic              started_ff, started_in;
   logic              exh_ff, exh_in;
   logic              done_ff, done_in;
   logic [perm_enum_pkg::COUNT_W-1:0] given_ff, given_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic [MAX_ELEMENTS-1:0] used_ff, used_in;
   logic [VAL_W-1:0]  placed_ff [MAX_ELEMENTS];
   logic [VAL_W-1:0]  placed_in [MAX_ELEMENTS];
   logic              rsp_valid_ff, rsp_valid_in;
   logic [perm_enum_pkg::DIGITS_W-1:0] digits_ff, digits_in;
   logic [perm_enum_pkg::COUNT_W-1:0]  number_ff, number_in;
   logic              exhausted_ff, exhausted_in;

   logic [VAL_W-1:0]  count_eff;
   logic [IDX_W-1:0]  last_pos;
   logic [VAL_W-1:0]  cur_value;
   logic [MAX_ELEMENTS-1:0] unmark_mask;
   logic [MAX_ELEMENTS-1:0] search_mask;
   logic [VAL_W-1:0]  search_floor;
   logic [MAX_ELEMENTS-1:0] pick_bit;
   logic [perm_enum_pkg::DIGITS_W-1:0] packed_digits;
   logic              req_take;
   logic              emit_load;
   perm_enum_pkg::find_result_type find_res;

   always_comb begin
      if (count_ff == '0) begin
         count_eff = VAL_W'(1);
      end else if (count_ff > MAX_CNT) begin
         count_eff = MAX_CNT;
      end else begin
         count_eff = count_ff;
      end
   end

   assign last_pos  = IDX_W'(count_eff - VAL_W'(1));
   assign cur_value = placed_ff[pos_ff];

   always_comb begin
      unmark_mask = '0;
      if (cur_value != '0 && cur_value <= count_eff) begin
         unmark_mask = ONE_BIT << IDX_W'(cur_value - VAL_W'(1));
      end
   end

   always_comb begin
      if (state_ff == perm_enum_pkg::ST_BACK) begin
         search_mask  = used_ff & ~unmark_mask;
         search_floor = cur_value;
      end else begin
         search_mask  = used_ff;
         search_floor = '0;
      end
   end

   perm_enum_find #(
      .MAX_ELEMENTS(MAX_ELEMENTS)
   ) u_find (
      .used_mask  (search_mask),
      .floor_value(search_floor),
      .limit_value(count_eff),
      .result     (find_res)
   );

   assign pick_bit = ONE_BIT << IDX_W'(find_res.value - VAL_W'(1));

   always_comb begin
      packed_digits = '0;
      for (int p = 0; p < SHOWN; p++) begin
         packed_digits[VAL_W*p +: VAL_W] = placed_ff[p];
      end
   end

   assign req_take  = req_valid && !req_stall;
   assign emit_load = (state_ff == perm_enum_pkg::ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      started_in = started_ff;
      exh_in     = exh_ff;
      done_in    = done_ff;
      given_in   = given_ff;
      pos_in     = pos_ff;
      used_in    = used_ff;
      placed_in  = placed_ff;
      rsp_valid_in = rsp_valid_ff;
      digits_in    = digits_ff;
      number_in    = number_ff;
      exhausted_in = exhausted_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         perm_enum_pkg::ST_IDLE: begin
            if (csr_write_enable) begin
               count_in   = csr_write_data;
               started_in = 1'b0;
            end
            if (req_take) begin
               if (req_restart || !started_ff) begin
                  for (int p = 0; p < MAX_ELEMENTS; p++) begin
                     if (p < int'(count_eff)) begin
                        placed_in[p] = VAL_W'(p + 1);
                        used_in[p]   = 1'b1;
                     end else begin
                        placed_in[p] = '0;
                        used_in[p]   = 1'b0;
                     end
                  end
                  given_in   = perm_enum_pkg::COUNT_W'(1);
                  started_in = 1'b1;
                  exh_in     = 1'b0;
                  done_in    = 1'b0;
                  state_in   = perm_enum_pkg::ST_EMIT;
               end else if (exh_ff) begin
                  done_in  = 1'b1;
                  state_in = perm_enum_pkg::ST_EMIT;
               end else begin
                  done_in  = 1'b0;
                  pos_in   = last_pos;
                  state_in = perm_enum_pkg::ST_BACK;
               end
            end
         end
         perm_enum_pkg::ST_BACK: begin
            if (find_res.found) begin
               placed_in[pos_ff] = find_res.value;
               used_in = search_mask | pick_bit;
               if (pos_ff == last_pos) begin
                  given_in = given_ff + perm_enum_pkg::COUNT_W'(1);
                  state_in = perm_enum_pkg::ST_EMIT;
               end else begin
                  pos_in   = pos_ff + IDX_W'(1);
                  state_in = perm_enum_pkg::ST_FILL;
               end
            end else begin
               placed_in[pos_ff] = '0;
               used_in = search_mask;
               if (pos_ff == '0) begin
                  exh_in   = 1'b1;
                  done_in  = 1'b1;
                  state_in = perm_enum_pkg::ST_EMIT;
               end else begin
                  pos_in = pos_ff - IDX_W'(1);
               end
            end
         end
         perm_enum_pkg::ST_FILL: begin
            placed_in[pos_ff] = find_res.value;
            used_in = used_ff | pick_bit;
            if (pos_ff == last_pos) begin
               given_in = given_ff + perm_enum_pkg::COUNT_W'(1);
               state_in = perm_enum_pkg::ST_EMIT;
            end else begin
               pos_in = pos_ff + IDX_W'(1);
            end
         end
         perm_enum_pkg::ST_EMIT: begin
            if (emit_load) begin
               rsp_valid_in = 1'b1;
               digits_in    = done_ff ? '0 : packed_digits;
               number_in    = given_ff;
               exhausted_in = done_ff;
               state_in     = perm_enum_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = perm_enum_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= perm_enum_pkg::ST_IDLE;
         count_ff     <= VAL_W'(4);
         started_ff   <= 1'b0;
         exh_ff       <= 1'b0;
         done_ff      <= 1'b0;
         given_ff     <= '0;
         pos_ff       <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         started_ff   <= started_in;
         exh_ff       <= exh_in;
         done_ff      <= done_in;
         given_ff     <= given_in;
         pos_ff       <= pos_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < MAX_ELEMENTS; p++) begin
            placed_ff[p] <= '0;
         end
      end else begin
         placed_ff <= placed_in;
      end
   end

   always_ff @(posedge clock) begin
      digits_ff    <= digits_in;
      number_ff    <= number_in;
      exhausted_ff <= exhausted_in;
   end

   assign req_stall       = (state_ff != perm_enum_pkg::ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_perm_digits = digits_ff;
   assign rsp_perm_number = number_ff;
   assign rsp_exhausted   = exhausted_ff;

   // exhausted word carries no digits
   a_exh_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && exhausted_ff |-> digits_ff == '0)
      else $error("exhausted word with nonzero digits");

   // busy right after taking a request
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_take |=> req_stall)
      else $error("request taken while not busy");

   // a new response only comes out of the emit step
   a_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == perm_enum_pkg::ST_EMIT))
      else $error("response without emit step");

   // a held permutation marks exactly n values
   a_marks: assert property (@(posedge clock) disable iff (reset)
      state_ff == perm_enum_pkg::ST_IDLE && started_ff && !exh_ff
      |-> $countones(used_ff) == int'(count_eff))
      else $error("used marks do not match element count");

endmodule

`default_nettype wire

// ===== test/permutation_enumerator_core_tb.sv =====
// testbench of permutation_enumerator_core: directed and random request words, with
// a self-checking permutation predictor; four phases idle none, req, rsp or both
// depends on perm_enum_pkg and the design files of permutation_enumerator_core
`timescale 1ns / 1ps

module permutation_enumerator_core_tb;

   localparam int VAL_W         = perm_enum_pkg::VAL_W;
   localparam int DIGITS_W      = perm_enum_pkg::DIGITS_W;
   localparam int COUNT_W       = perm_enum_pkg::COUNT_W;
   localparam int SHOWN_MAX     = perm_enum_pkg::SHOWN_MAX;
   localparam int PERM_MAX      = perm_enum_pkg::MAX_ELEMENTS_DEF;
   localparam int STUCK_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 2 * PERM_MAX + 16;

   typedef struct packed {
      logic [DIGITS_W-1:0] digits;
      logic [COUNT_W-1:0]  number;
      logic                exhausted;
   } perm_word_type;

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                csr_write_enable = 1'b0;
   logic [VAL_W-1:0]    csr_write_data   = '0;
   logic                req_valid        = 1'b0;
   logic                req_stall;
   logic                req_restart      = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall        = 1'b0;
   logic [DIGITS_W-1:0] rsp_perm_digits;
   logic [COUNT_W-1:0]  rsp_perm_number;
   logic                rsp_exhausted;

   // predictor state
   logic [VAL_W-1:0]    slot_value  [PERM_MAX];
   logic                value_taken [PERM_MAX];
   logic [VAL_W-1:0]    search_depth;
   logic [COUNT_W-1:0]  perm_total;
   logic                search_live;
   logic [VAL_W-1:0]    element_reg;

   perm_word_type       perm_expected [$];
   int                  fail_count   = 0;
   int                  stuck_cycles = 0;
   int                  send_idle_pct = 0;
   int                  stall_pct     = 0;

   permutation_enumerator_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_perm_digits  (rsp_perm_digits),
      .rsp_perm_number  (rsp_perm_number),
      .rsp_exhausted    (rsp_exhausted)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned active_elements();
      int unsigned n;
      n = 32'(element_reg);
      if (n < 1) n = 1;
      if (n > PERM_MAX) n = PERM_MAX;
      return n;
   endfunction

   // smallest unused values into slots from..n-1
   function automatic void fill_slots(int unsigned from, int unsigned n);
      bit placed;
      for (int unsigned p = from; p < n; p++) begin
         placed = 1'b0;
         for (int unsigned v = 1; v <= n; v++) begin
            if (!placed && !value_taken[v-1]) begin
               slot_value[p]    = VAL_W'(v);
               value_taken[v-1] = 1'b1;
               placed           = 1'b1;
            end
         end
      end
   endfunction

   function automatic void first_permutation(int unsigned n);
      for (int p = 0; p < PERM_MAX; p++) begin
         slot_value[p]  = '0;
         value_taken[p] = 1'b0;
      end
      fill_slots(0, n);
      search_depth = VAL_W'(n);
      perm_total   = COUNT_W'(1);
      search_live  = 1'b1;
   endfunction

   function automatic bit next_permutation(int unsigned n);
      int unsigned lev;
      int unsigned p;
      int unsigned v;
      lev = n;
      while (lev >= 1) begin
         p = lev - 1;
         v = 32'(slot_value[p]);
         if (v >= 1 && v <= n) value_taken[v-1] = 1'b0;
         slot_value[p] = '0;
         for (int unsigned w = v + 1; w <= n; w++) begin
            if (!value_taken[w-1]) begin
               slot_value[p]    = VAL_W'(w);
               value_taken[w-1] = 1'b1;
               fill_slots(p + 1, n);
               search_depth = VAL_W'(n);
               return 1'b1;
            end
         end
         lev--;
      end
      search_depth = '0;
      return 1'b0;
   endfunction

   function automatic perm_word_type predict_word(logic restart);
      int unsigned   n;
      bit            done;
      perm_word_type word;
      n    = active_elements();
      done = 1'b0;
      word = '0;
      if (restart || !search_live) first_permutation(n);
      else if (search_depth == 0) done = 1'b1;
      else if (next_permutation(n)) perm_total = perm_total + 1'b1;
      else done = 1'b1;
      if (!done) begin
         for (int unsigned p = 0; p < n && p < SHOWN_MAX; p++)
            word.digits[VAL_W*p +: VAL_W] = slot_value[p];
      end
      word.number    = perm_total;
      word.exhausted = done;
      return word;
   endfunction

   // called at a falling edge, returns at a falling edge with valid left as is
   task automatic send_request(input logic restart);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      perm_expected.push_back(predict_word(restart));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (perm_expected.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_element_count(input logic [VAL_W-1:0] value);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      element_reg = value;
      search_live = 1'b0;
   endtask

   task automatic test_next_before_start();
      send_request(1'b0);
      send_request(1'b0);
      send_request(1'b1);
      send_request(1'b0);
   endtask

   task automatic test_single_element();
      write_element_count(4'd1);
      send_request(1'b1);
      send_request(1'b0);
      send_request(1'b0);
      send_request(1'b1);
   endtask

   task automatic test_count_out_of_range();
      write_element_count(4'd0);
      send_request(1'b0);
      send_request(1'b0);
      write_element_count(4'd15);
      send_request(1'b0);
      send_request(1'b0);
      send_request(1'b1);
   endtask

   task automatic test_full_enumeration();
      write_element_count(4'd2);
      repeat (4) send_request(1'b0);
      write_element_count(4'd3);
      repeat (7) send_request(1'b0);
   endtask

   task automatic test_widest_count();
      write_element_count(4'd8);
      send_request(1'b1);
      send_request(1'b0);
   endtask

   task automatic test_random(input int sender_pct, input int receiver_pct,
                              input int unsigned item_goal);
      int unsigned sent;
      int unsigned n;
      int unsigned len;
      int unsigned fact;
      send_idle_pct = sender_pct;
      stall_pct     = receiver_pct;
      sent = 0;
      while (sent < item_goal) begin
         if ($urandom_range(99) < 70) n = $urandom_range(5);
         else n = $urandom_range(15, 6);
         write_element_count(VAL_W'(n));
         fact = 1;
         for (int unsigned k = 2; k <= n; k++) fact = fact * k;
         if (n <= 4 || (n == 5 && $urandom_range(1) == 1)) len = fact + $urandom_range(3, 1);
         else len = $urandom_range(40, 5);
         for (int unsigned i = 0; i < len; i++) send_request($urandom_range(99) < 2);
         sent = sent + len;
      end
      wait_drained();
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      perm_word_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (perm_expected.size() == 0) begin
            $display("%0t unexpected word digits %h number %0d exhausted %b",
                     $time, rsp_perm_digits, rsp_perm_number, rsp_exhausted);
            fail_count++;
         end else begin
            want = perm_expected.pop_front();
            if (rsp_perm_digits !== want.digits) begin
               $display("%0t perm_digits expected %h actual %h",
                        $time, want.digits, rsp_perm_digits);
               fail_count++;
            end
            if (rsp_perm_number !== want.number) begin
               $display("%0t perm_number expected %0d actual %0d",
                        $time, want.number, rsp_perm_number);
               fail_count++;
            end
            if (rsp_exhausted !== want.exhausted) begin
               $display("%0t exhausted expected %b actual %b",
                        $time, want.exhausted, rsp_exhausted);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles == STUCK_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      for (int p = 0; p < PERM_MAX; p++) begin
         slot_value[p]  = '0;
         value_taken[p] = 1'b0;
      end
      search_depth = VAL_W'(1);
      perm_total   = '0;
      search_live  = 1'b0;
      element_reg  = 4'd4;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_next_before_start();
      test_single_element();
      test_count_out_of_range();
      test_full_enumeration();
      test_widest_count();
      test_random(0, 0, 120);
      test_random(47, 0, 120);
      test_random(0, 47, 120);
      test_random(38, 38, 120);

      wait_drained();
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
